// File: hw/rtl/ats_pkg.sv
// Shared constants, types and command/status structs of the access time sketch.
package ats_pkg;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned LEVELS      = 4;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  localparam int unsigned HASH_W      = 64;
  localparam int unsigned SEC_W       = 63;
  localparam int unsigned MEM_W       = SEC_W + 1;
  localparam int unsigned IN_TDATA_W  = ((HASH_W + SEC_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((SEC_W + 7) / 8) * 8;

  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(TABLE_DEPTH - 1);

  // XXH64 primes
  localparam logic [63:0] XP1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] XP2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] XP3 = 64'h165667B19E3779F9;
  localparam logic [63:0] XP4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] XP5 = 64'h27D4EB2F165667C5;
  // seed 0, 8-byte input: accumulator start value
  localparam logic [63:0] XSEED = XP5 + 64'd8;

  // One rehash is five multiplies; the step names the operand preparation.
  typedef enum logic [2:0] {
    XS_V,     // v * XP2
    XS_K,     // rotl(t, 31) * XP1
    XS_H27,   // rotl(seed ^ k, 27) * XP1
    XS_AV33,  // (x ^ x >> 33) * XP2, x = u + XP4
    XS_X29    // (h ^ h >> 29) * XP3
  } xstep_t;

  // Phases of a 64x64 low-half multiply on one 32x32 multiplier.
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_LO,
    MUL_CROSS_A,
    MUL_CROSS_B
  } mul_op_t;

  typedef struct packed {
    logic    load;       // latch the accepted word, clear the running minimum
    logic    clear;      // clearing sweep write
    logic    mem_acc;    // table access at the current level
    logic    pre;        // latch the multiplier operand
    mul_op_t mul;
    xstep_t  step;
    logic    hash_done;  // last multiply of a rehash: update the hash
    logic    out_load;   // move the lookup result into the output register
  } ats_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_lookup;
    logic out_free;
  } ats_sts_t;

endpackage

// File: hw/rtl/ats_ctrl.sv
// Controller state machine of the access time sketch.
module ats_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ats_pkg::ats_sts_t sts,
  output ats_pkg::ats_cmd_t cmd
);
  import ats_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACCESS,
    S_PRE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_FINISH
  } state_t;

  state_t           state_r, state_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  xstep_t           step_r, step_nxt;

  logic last_lvl;
  assign last_lvl  = (lvl_r == LVL_W'(LEVELS - 1));
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.mul   = MUL_NONE;
    cmd.step  = step_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          lvl_nxt   = '0;
          state_nxt = S_ACCESS;
        end
      end
      S_ACCESS: begin
        cmd.mem_acc = 1'b1;
        step_nxt    = XS_V;
        if (!last_lvl) begin
          state_nxt = S_PRE;
        end else if (sts.is_lookup) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PRE: begin
        cmd.pre   = 1'b1;
        state_nxt = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul   = MUL_LO;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul   = MUL_CROSS_A;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul   = MUL_CROSS_B;
        state_nxt = S_PRE;
        unique case (step_r)
          XS_V:    step_nxt = XS_K;
          XS_K:    step_nxt = XS_H27;
          XS_H27:  step_nxt = XS_AV33;
          XS_AV33: step_nxt = XS_X29;
          XS_X29: begin
            cmd.hash_done = 1'b1;
            lvl_nxt       = lvl_r + LVL_W'(1);
            state_nxt     = S_ACCESS;
          end
          default: step_nxt = XS_V;
        endcase
      end
      S_FINISH: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      lvl_r   <= '0;
      step_r  <= XS_V;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// File: hw/rtl/ats_datapath.sv
// Datapath of the access time sketch: table, XXH64 multiply unit, minimum, output register.
module ats_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ats_pkg::ats_cmd_t                  cmd,
  output ats_pkg::ats_sts_t                  sts,
  input  logic                               in_tuser,
  input  logic [ats_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic                               out_tuser,
  output logic [ats_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import ats_pkg::*;

  logic             mode_r;
  logic [63:0]      h_r;
  logic [SEC_W-1:0] secs_r;
  logic [63:0]      w_r;
  logic [63:0]      a_r;
  logic [63:0]      acc_r;
  logic [SEC_W-1:0] best_r, best_nxt;
  logic             found_r, found_nxt;
  logic             rd_pend_r;
  logic [IDX_W-1:0] clr_addr_r;
  logic [MEM_W-1:0] rdata_r;
  logic             out_valid_r;
  logic             out_found_r;
  logic [SEC_W-1:0] out_est_r;

  logic [MEM_W-1:0] stamp_mem [TABLE_DEPTH];

  logic [IDX_W-1:0] idx;
  logic [63:0]      pre_val;
  logic [63:0]      xsum;
  logic [63:0]      mconst;
  logic [31:0]      mx, my;
  logic [63:0]      mprod;
  logic [63:0]      mfull;
  logic             hit;

  assign idx = h_r[IDX_W-1:0] & IDX_MASK;

  assign sts.clr_done  = (clr_addr_r == IDX_MASK);
  assign sts.is_lookup = mode_r;
  assign sts.out_free  = !out_valid_r || out_tready;

  // operand preparation ahead of each multiply
  always_comb begin
    xsum = w_r + XP4;
    case (cmd.step)
      XS_V:    pre_val = h_r;
      XS_K:    pre_val = {w_r[32:0], w_r[63:33]};
      XS_H27:  pre_val = {(XSEED[36:0] ^ w_r[36:0]), (XSEED[63:37] ^ w_r[63:37])};
      XS_AV33: pre_val = xsum ^ (xsum >> 33);
      XS_X29:  pre_val = w_r ^ (w_r >> 29);
      default: pre_val = h_r;
    endcase
    case (cmd.step)
      XS_V:    mconst = XP2;
      XS_K:    mconst = XP1;
      XS_H27:  mconst = XP1;
      XS_AV33: mconst = XP2;
      XS_X29:  mconst = XP3;
      default: mconst = XP2;
    endcase
  end

  // one 32x32 multiplier: low product, then the two cross terms
  always_comb begin
    case (cmd.mul)
      MUL_CROSS_A: begin
        mx = a_r[31:0];
        my = mconst[63:32];
      end
      MUL_CROSS_B: begin
        mx = a_r[63:32];
        my = mconst[31:0];
      end
      default: begin
        mx = a_r[31:0];
        my = mconst[31:0];
      end
    endcase
    mprod = 64'(mx) * 64'(my);
    mfull = acc_r + {mprod[31:0], 32'd0};
  end

  // running minimum over valid slots
  always_comb begin
    hit       = rd_pend_r && rdata_r[MEM_W-1];
    best_nxt  = best_r;
    found_nxt = found_r | hit;
    if (hit && (!found_r || (rdata_r[SEC_W-1:0] < best_r))) begin
      best_nxt = rdata_r[SEC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      stamp_mem[clr_addr_r] <= '0;
    end else if (cmd.mem_acc && !mode_r) begin
      stamp_mem[idx] <= {1'b1, secs_r};
    end
    if (cmd.mem_acc && mode_r) begin
      rdata_r <= stamp_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_tuser;
      h_r    <= in_tdata[HASH_W-1:0];
      secs_r <= in_tdata[HASH_W+SEC_W-1:HASH_W];
      best_r <= '0;
    end else begin
      best_r <= best_nxt;
    end
    if (cmd.pre) begin
      a_r <= pre_val;
    end
    case (cmd.mul)
      MUL_LO:      acc_r <= mprod;
      MUL_CROSS_A: acc_r <= mfull;
      MUL_CROSS_B: begin
        w_r <= mfull;
        if (cmd.hash_done) begin
          h_r <= mfull ^ (mfull >> 32);
        end
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      out_found_r <= found_nxt;
      out_est_r   <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      found_r     <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + IDX_W'(1);
      end
      found_r   <= cmd.load ? 1'b0 : found_nxt;
      rd_pend_r <= cmd.mem_acc && mode_r;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = OUT_TDATA_W'(out_est_r);

endmodule

// File: hw/rtl/access_time_sketch_unit.sv
// Top level of the access time sketch: controller plus datapath.
//
// Sketch of last-access timestamps keyed by a 64-bit hash. Each input word
// either inserts a timestamp (in_tuser = 0) or looks one up (in_tuser = 1).
// At each of LEVELS levels the slot is the hash ANDed with TABLE_DEPTH-1;
// between levels the hash is replaced by its XXH64 (seed 0).
// An insert writes every indexed slot and returns no word. A lookup returns
// one word: out_tuser = found, out_tdata = minimum valid stored seconds.
//
// Timing: one word at a time. Most of the time a word takes goes to the
// rehash: five 64-bit multiplies, each run on the single shared 32x32
// multiplier as operand prep, low product and two cross terms.
// Reset: the table is swept invalid, one entry a cycle, all TABLE_DEPTH
// entries (4096), with in_tready low throughout.
// Stall: the result sits in an output register; the next word is accepted
// while it waits, and a lookup that finishes behind it holds until it is taken.
module access_time_sketch_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic                             in_tuser,   // [0] mode
  input  logic [ats_pkg::IN_TDATA_W-1:0]   in_tdata,   // [63:0] key_hash, [126:64] time_seconds
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic                             out_tuser,  // [0] found
  output logic [ats_pkg::OUT_TDATA_W-1:0]  out_tdata   // [62:0] estimate_seconds
);
  import ats_pkg::*;

  ats_cmd_t cmd;
  ats_sts_t sts;

  ats_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ats_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

// File: hw/rtl/ats_checker.sv
// Port-level checks of the access time sketch, bound to the top level.
module ats_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic                            out_tuser,
  input logic [ats_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ats_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // a miss reports zero seconds
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss with nonzero estimate");

  // one word in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a word while busy");

  // reset starts the clearing sweep with the output empty
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("not idle-cleared after reset");

endmodule

bind access_time_sketch_unit ats_checker u_ats_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench of the access time sketch: directed table, then random words.
module testbench;
  import ats_pkg::*;

  // Mode codes carried on in_tuser.
  localparam bit MODE_INSERT = 1'b0;
  localparam bit MODE_LOOKUP = 1'b1;

  localparam logic [SEC_W-1:0]  SEC_MAX  = {SEC_W{1'b1}};
  localparam logic [HASH_W-1:0] HASH_MAX = {HASH_W{1'b1}};

  // Cycles a word may still be in flight after its last answer.
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_WORDS = 1030;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic             found;
    logic [SEC_W-1:0] estimate;
  } lookup_answer_t;

  // One row of the directed table; pinned rows carry an answer typed in by hand.
  typedef struct {
    bit                mode;
    logic [HASH_W-1:0] key_hash;
    logic [SEC_W-1:0]  seconds;
    bit                pinned;
    bit                pin_found;
    logic [SEC_W-1:0]  pin_estimate;
  } probe_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic                   in_tuser;    // [0] mode
  logic [IN_TDATA_W-1:0]  in_tdata;    // [63:0] key_hash, [126:64] time_seconds, [127] zero
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   out_tuser;   // [0] found
  logic [OUT_TDATA_W-1:0] out_tdata;   // [62:0] estimate_seconds, [63] zero

  // Shadow copy of the timestamp table: stored seconds plus a valid flag per slot.
  logic [SEC_W-1:0] shadow_stamp [TABLE_DEPTH];
  bit               shadow_valid [TABLE_DEPTH];

  lookup_answer_t pending_answers[$];
  probe_row_t     probe_rows[$];
  logic [HASH_W-1:0] recent_keys[$];

  int  mismatch_count;
  bit  calm;

  access_time_sketch_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop well past the slowest legal run: the reset sweep plus about
  // 1050 words, with the worst gaps and stalls on both sides.
  initial begin
    #8000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // XXH64, seed 0, of the eight little-endian bytes of a 64-bit value.
  function automatic logic [63:0] xxh64_of_word(input logic [63:0] v);
    logic [63:0] acc;
    logic [63:0] lane;
    begin
      acc  = XP5 + 64'd8;
      lane = v * XP2;
      lane = {lane[32:0], lane[63:33]} * XP1;        // rotate left 31
      acc  = acc ^ lane;
      acc  = {acc[36:0], acc[63:37]} * XP1 + XP4;    // rotate left 27
      acc  = acc ^ (acc >> 33);
      acc  = acc * XP2;
      acc  = acc ^ (acc >> 29);
      acc  = acc * XP3;
      acc  = acc ^ (acc >> 32);
      return acc;
    end
  endfunction

  // Apply one accepted word to the shadow table; lookups yield an answer.
  task automatic update_shadow(input bit mode, input logic [HASH_W-1:0] key_hash,
                               input logic [SEC_W-1:0] seconds,
                               output lookup_answer_t answer);
    logic [63:0] walk;
    int unsigned slot;
    begin
      walk   = key_hash;
      answer = '0;
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
        slot = int'(walk & 64'(TABLE_DEPTH - 1));
        if (mode == MODE_INSERT) begin
          shadow_stamp[slot] = seconds;
          shadow_valid[slot] = 1'b1;
        end else if (shadow_valid[slot]) begin
          if (!answer.found || shadow_stamp[slot] < answer.estimate)
            answer.estimate = shadow_stamp[slot];
          answer.found = 1'b1;
        end
        if (lvl + 1 < LEVELS)
          walk = xxh64_of_word(walk);
      end
    end
  endtask

  // Offer one word after a random gap, hold it until taken, then book its answer.
  task automatic push_word(input bit mode, input logic [HASH_W-1:0] key_hash,
                           input logic [SEC_W-1:0] seconds, input bit pinned,
                           input lookup_answer_t pinned_answer);
    int gap;
    lookup_answer_t predicted;
    begin
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tuser  <= mode;
      in_tdata  <= {1'b0, seconds, key_hash};
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      update_shadow(mode, key_hash, seconds, predicted);
      if (mode == MODE_LOOKUP)
        pending_answers.push_back(pinned ? pinned_answer : predicted);
      if (mode == MODE_INSERT) begin
        recent_keys.push_back(key_hash);
        if (recent_keys.size() > 24)
          void'(recent_keys.pop_front());
      end
    end
  endtask

  // Drop valid and hold off until every booked answer has come back.
  task automatic wait_for_drain();
    begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while (pending_answers.size() != 0) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] random_hash();
    return {$urandom(), $urandom()};
  endfunction

  // Seconds: mostly random over the full field, now and then an extreme.
  function automatic logic [SEC_W-1:0] random_seconds();
    int pick;
    begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        return '0;
      if (pick == 1)
        return SEC_MAX;
      return SEC_W'({$urandom(), $urandom()});
    end
  endfunction

  // Result side: take words after a random stall and compare with the oldest answer.
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    lookup_answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result word: found %0b estimate %h", out_tuser, out_tdata);
      end else begin
        want = pending_answers.pop_front();
        if (out_tuser !== want.found || out_tdata !== {1'b0, want.estimate}) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("lookup mismatch: expected found %0b estimate %h, got found %0b tdata %h",
                     want.found, want.estimate, out_tuser, out_tdata);
        end
      end
    end
  end

  // Stimulus: reset, directed table, random words, drain, verdict.
  initial begin
    lookup_answer_t pin;
    lookup_answer_t none;
    logic [HASH_W-1:0] key_hash;
    bit mode;
    int roll;

    mismatch_count = 0;
    calm           = 1'b0;
    none           = '0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tuser       = MODE_INSERT;
    in_tdata       = '0;
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      shadow_stamp[s] = '0;
      shadow_valid[s] = 1'b0;
    end

    // Directed table. Pinned answers: empty table, and a lookup after an insert
    // of the same key with no insert between, which sees that insert in every slot.
    probe_rows.push_back('{MODE_LOOKUP, 64'h0,      SEC_W'(0), 1, 0, SEC_W'(0)});
    probe_rows.push_back('{MODE_LOOKUP, HASH_MAX,   SEC_MAX,   1, 0, SEC_W'(0)});
    probe_rows.push_back('{MODE_INSERT, 64'h0,      SEC_MAX,   0, 0, SEC_W'(0)});
    probe_rows.push_back('{MODE_LOOKUP, 64'h0,      SEC_W'(0), 1, 1, SEC_MAX});
    probe_rows.push_back('{MODE_INSERT, 64'h0,      SEC_W'(0), 0, 0, SEC_W'(0)});
    probe_rows.push_back('{MODE_LOOKUP, 64'h0,      SEC_MAX,   1, 1, SEC_W'(0)});
    probe_rows.push_back('{MODE_INSERT, HASH_MAX,   SEC_W'({(SEC_W+1)/2{2'b01}}), 0, 0,
                           SEC_W'(0)});
    probe_rows.push_back('{MODE_LOOKUP, HASH_MAX,   SEC_W'(0), 1, 1,
                           SEC_W'({(SEC_W+1)/2{2'b01}})});
    // Same first slot as key zero: overwrite one of its slots.
    probe_rows.push_back('{MODE_INSERT, 64'h1000,   SEC_W'(123), 0, 0, SEC_W'(0)});
    probe_rows.push_back('{MODE_LOOKUP, 64'h0,      SEC_W'(0), 0, 0, SEC_W'(0)});
    probe_rows.push_back('{MODE_LOOKUP, 64'h1000,   SEC_W'(0), 1, 1, SEC_W'(123)});
    probe_rows.push_back('{MODE_INSERT, {32{2'b10}}, SEC_W'({(SEC_W+1)/2{2'b10}}), 0, 0,
                           SEC_W'(0)});
    probe_rows.push_back('{MODE_LOOKUP, {32{2'b10}}, SEC_MAX,  1, 1,
                           SEC_W'({(SEC_W+1)/2{2'b10}})});
    // Never inserted: may see stray slots of other keys.
    probe_rows.push_back('{MODE_LOOKUP, {32{2'b01}}, SEC_W'(0), 0, 0, SEC_W'(0)});
    probe_rows.push_back('{MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_F000, SEC_MAX, 0, 0, SEC_W'(0)});
    probe_rows.push_back('{MODE_INSERT, 64'h8000_0000_0000_0000, SEC_W'(1), 0, 0, SEC_W'(0)});
    probe_rows.push_back('{MODE_LOOKUP, 64'h8000_0000_0000_0000, SEC_W'(0), 1, 1, SEC_W'(1)});
    probe_rows.push_back('{MODE_INSERT, 64'h0000_0000_0000_0FFF, SEC_MAX - 1, 0, 0, SEC_W'(0)});
    probe_rows.push_back('{MODE_LOOKUP, HASH_MAX,   SEC_W'(0), 0, 0, SEC_W'(0)});
    probe_rows.push_back('{MODE_LOOKUP, 64'h0000_0000_0000_0FFF, SEC_W'(0), 1, 1, SEC_MAX - 1});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // The block sweeps its table after reset with in_tready low; the
    // handshake wait in push_word covers that.
    foreach (probe_rows[r]) begin
      pin.found    = probe_rows[r].pin_found;
      pin.estimate = probe_rows[r].pin_estimate;
      push_word(probe_rows[r].mode, probe_rows[r].key_hash, probe_rows[r].seconds,
                probe_rows[r].pinned, pin);
    end

    // Let the pipe run dry once before the random part.
    wait_for_drain();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // Run a stretch with no gaps or stalls on either side.
      calm = (i >= 300 && i < 380);
      if (i == 600)
        wait_for_drain();
      mode = ($urandom_range(0, 99) < 45) ? MODE_INSERT : MODE_LOOKUP;
      roll = $urandom_range(0, 99);
      key_hash = random_hash();
      if (recent_keys.size() != 0) begin
        if (mode == MODE_LOOKUP && roll < 70)
          key_hash = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        else if (mode == MODE_INSERT && roll < 25)
          key_hash = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        else if (roll < 85)
          // Keep the slot bits of a live key, scramble the rest: forced collision.
          key_hash[IDX_W-1:0] = recent_keys[$urandom_range(0, recent_keys.size() - 1)]
                                 [IDX_W-1:0];
      end
      push_word(mode, key_hash, random_seconds(), 1'b0, none);
    end
    calm = 1'b0;

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_answers.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ats_pkg.sv
hw/rtl/ats_ctrl.sv
hw/rtl/ats_datapath.sv
hw/rtl/access_time_sketch_unit.sv
hw/rtl/ats_checker.sv
tb/testbench.sv
